// ===== sv/gipp_pkg.sv =====
// Shared types and constants for the GIF interlaced pixel placer.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package gipp_pkg;

    // Input command codes (s_tuser)
    localparam logic [1:0] CMD_PIXEL   = 2'd0;
    localparam logic [1:0] CMD_PAL_WR  = 2'd1;
    localparam logic [1:0] CMD_SOF     = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] REG_SCREEN_WIDTH      = 3'd0;
    localparam logic [2:0] REG_FRAME_LEFT        = 3'd1;
    localparam logic [2:0] REG_FRAME_TOP         = 3'd2;
    localparam logic [2:0] REG_FRAME_WIDTH       = 3'd3;
    localparam logic [2:0] REG_FRAME_HEIGHT      = 3'd4;
    localparam logic [2:0] REG_INTERLACED        = 3'd5;
    localparam logic [2:0] REG_TRANSPARENCY_ON   = 3'd6;
    localparam logic [2:0] REG_TRANSPARENT_INDEX = 3'd7;

    // Interlace pass table
    localparam int         INTERLACE_PASSES = 4;
    localparam logic [1:0] LAST_PASS        = 2'd3;
    localparam logic [3:0] PASS_START [INTERLACE_PASSES] = '{4'd0, 4'd4, 4'd2, 4'd1};
    localparam logic [3:0] PASS_STEP  [INTERLACE_PASSES] = '{4'd8, 4'd8, 4'd4, 4'd2};

    // Front-to-back queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    typedef struct packed {
        logic [15:0] screen_width;
        logic [15:0] frame_left;
        logic [15:0] frame_top;
        logic [15:0] frame_width;
        logic [15:0] frame_height;
        logic        interlaced;
        logic        transparency_on;
        logic [7:0]  transparent_index;
    } cfg_t;

    // One queued job: a palette write or a placed pixel
    typedef struct packed {
        logic        is_pal;
        logic        we;
        logic        done;
        logic [7:0]  idx;
        logic [23:0] rgb;      // {red, green, blue} for a palette write
        logic [17:0] row_sum;  // row + frame_top
        logic [15:0] col;
    } job_t;

endpackage

// ===== sv/gif_interlaced_pixel_placer.sv =====
// Top level of the GIF interlaced pixel placer: config registers, front, queue, back.
// Depends on gipp_pkg, gipp_front, gipp_fifo, gipp_back.
`timescale 1ns / 1ps

// Usage
//   Input stream s_*: one item per handshake. s_tuser carries the command
//   (pixel index, palette write, start of frame); s_tdata carries the index
//   and, for palette writes, the colour.
//   Output stream m_*: one item per placed pixel: frame-buffer address and
//   colour in m_tdata, write enable in m_tuser, m_tlast high on the pixel
//   that completes the last row of the sub-image.
//   Config port cfg_*: always ready; write registers only while the block
//   is idle (all results drained).
//   Path: queue write at the accepting edge, then palette read plus multiply
//   into stage 1, then address add into the output register that drives m_tvalid.
//   Throughput: one item per cycle while the output is not stalled; the front
//   updates column/row/pass on each accepted item, the back does one queue pop per cycle.
//   Palette writes and ignored items give no output item.
//   Stall: when m_tready is low the output register and stage 1 hold, the
//   4-entry queue fills, and s_tready drops once it is full.
//   Reset: position state clears, registers take their reset values and the
//   palette reads as a gray ramp (per-entry valid bits) until written.

module gif_interlaced_pixel_placer
#(
    parameter int PALETTE_ENTRIES = 256
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // color_index[7:0], red_in[15:8], green_in[23:16], blue_in[31:24]
    input  logic [1:0]  s_tuser,   // cmd[1:0]

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // pixel_address[31:0], red_out[39:32], green_out[47:40],
                                   // blue_out[55:48]
    output logic        m_tuser,   // write_enable
    output logic        m_tlast,   // frame_done

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    gipp_pkg::cfg_t cfg_reg;
    gipp_pkg::job_t q_din, q_dout;
    logic           q_push, q_pop, q_full, q_empty;
    logic [23:0]    rgb_out;
    logic [31:0]    pixel_address;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.screen_width      <= 16'd1;
            cfg_reg.frame_left        <= 16'd0;
            cfg_reg.frame_top         <= 16'd0;
            cfg_reg.frame_width       <= 16'd1;
            cfg_reg.frame_height      <= 16'd1;
            cfg_reg.interlaced        <= 1'b0;
            cfg_reg.transparency_on   <= 1'b0;
            cfg_reg.transparent_index <= 8'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                gipp_pkg::REG_SCREEN_WIDTH:      cfg_reg.screen_width      <= cfg_data;
                gipp_pkg::REG_FRAME_LEFT:        cfg_reg.frame_left        <= cfg_data;
                gipp_pkg::REG_FRAME_TOP:         cfg_reg.frame_top         <= cfg_data;
                gipp_pkg::REG_FRAME_WIDTH:       cfg_reg.frame_width       <= cfg_data;
                gipp_pkg::REG_FRAME_HEIGHT:      cfg_reg.frame_height      <= cfg_data;
                gipp_pkg::REG_INTERLACED:        cfg_reg.interlaced        <= cfg_data[0];
                gipp_pkg::REG_TRANSPARENCY_ON:   cfg_reg.transparency_on   <= cfg_data[0];
                gipp_pkg::REG_TRANSPARENT_INDEX: cfg_reg.transparent_index <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Front: position tracking and classification
    gipp_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .cmd         (s_tuser),
        .color_index (s_tdata[7:0]),
        .rgb         ({s_tdata[15:8], s_tdata[23:16], s_tdata[31:24]}),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_din       (q_din)
    );

    // Decouples the front from output back-pressure
    gipp_fifo u_fifo
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_din),
        .full  (q_full),
        .pop   (q_pop),
        .dout  (q_dout),
        .empty (q_empty)
    );

    // Back: palette lookup/update and address generation
    gipp_back #(.PALETTE_ENTRIES(PALETTE_ENTRIES)) u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .q_empty       (q_empty),
        .q_dout        (q_dout),
        .q_pop         (q_pop),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .write_enable  (m_tuser),
        .pixel_address (pixel_address),
        .rgb_out       (rgb_out),
        .frame_done    (m_tlast)
    );

    // rgb_out is {red, green, blue}
    assign m_tdata = {rgb_out[7:0], rgb_out[15:8], rgb_out[23:16], pixel_address};

endmodule

// ===== sv/gipp_front.sv =====
// Front end: accepts input items, tracks column/row/interlace pass, emits jobs.
// Depends on gipp_pkg.
`timescale 1ns / 1ps

module gipp_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  gipp_pkg::cfg_t  cfg,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [1:0]      cmd,
    input  logic [7:0]      color_index,
    input  logic [23:0]     rgb,
    input  logic            q_full,
    output logic            q_push,
    output gipp_pkg::job_t  q_din
);

    logic [15:0] col_reg, col_next;
    logic [16:0] row_reg, row_next;
    logic [1:0]  pass_reg, pass_next;
    logic        fin_reg, fin_next;
    logic        accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        logic [15:0] col_inc;
        logic [16:0] r;
        logic [1:0]  p;
        logic [16:0] height17;
        col_inc   = col_reg + 16'd1;
        height17  = {1'b0, cfg.frame_height};
        r         = row_reg;
        p         = pass_reg;
        col_next  = col_reg;
        row_next  = row_reg;
        pass_next = pass_reg;
        fin_next  = fin_reg;
        if (accept)
        begin
            case (cmd)
                gipp_pkg::CMD_SOF:
                begin
                    col_next  = '0;
                    row_next  = '0;
                    pass_next = '0;
                    fin_next  = 1'b0;
                end
                gipp_pkg::CMD_PIXEL:
                begin
                    if (!fin_reg)
                    begin
                        col_next = col_inc;
                        if (col_inc >= cfg.frame_width)
                        begin
                            col_next = '0;
                            if (cfg.interlaced)
                            begin
                                r = row_reg + {13'd0, gipp_pkg::PASS_STEP[p]};
                                // skip passes that start past the bottom
                                for (int k = 0; k < gipp_pkg::INTERLACE_PASSES - 1; k++)
                                begin
                                    if (r >= height17 && p != gipp_pkg::LAST_PASS)
                                    begin
                                        p = p + 2'd1;
                                        r = {13'd0, gipp_pkg::PASS_START[p]};
                                    end
                                end
                            end
                            else
                            begin
                                r = row_reg + 17'd1;
                            end
                            row_next  = r;
                            pass_next = p;
                            if (r >= height17)
                                fin_next = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        q_push = accept && ((cmd == gipp_pkg::CMD_PIXEL && !fin_reg) ||
                            cmd == gipp_pkg::CMD_PAL_WR);
        q_din.is_pal  = (cmd == gipp_pkg::CMD_PAL_WR);
        q_din.we      = !(cfg.transparency_on && color_index == cfg.transparent_index);
        q_din.done    = fin_next;
        q_din.idx     = color_index;
        q_din.rgb     = rgb;
        q_din.row_sum = {1'b0, row_reg} + {2'b00, cfg.frame_top};
        q_din.col     = col_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            pass_reg <= '0;
            fin_reg  <= 1'b0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            pass_reg <= pass_next;
            fin_reg  <= fin_next;
        end
    end

endmodule

// ===== sv/gipp_fifo.sv =====
// Short job queue between front and back ends.
// Depends on gipp_pkg.
`timescale 1ns / 1ps

module gipp_fifo
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  gipp_pkg::job_t  din,
    output logic            full,
    input  logic            pop,
    output gipp_pkg::job_t  dout,
    output logic            empty
);

    gipp_pkg::job_t                      slot_reg [gipp_pkg::QUEUE_DEPTH];
    logic [gipp_pkg::QUEUE_AW-1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [gipp_pkg::QUEUE_AW:0]         count_reg, count_next;

    assign full  = (count_reg == (gipp_pkg::QUEUE_AW + 1)'(gipp_pkg::QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign dout  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= din;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

// ===== sv/gipp_back.sv =====
// Back end: palette memory, address multiply/add and output register.
// Depends on gipp_pkg.
`timescale 1ns / 1ps

module gipp_back
#(
    parameter int PALETTE_ENTRIES = 256
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  gipp_pkg::cfg_t  cfg,
    input  logic            q_empty,
    input  gipp_pkg::job_t  q_dout,
    output logic            q_pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic            write_enable,
    output logic [31:0]     pixel_address,
    output logic [23:0]     rgb_out,
    output logic            frame_done
);

    localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

    logic [23:0]          mem [PALETTE_ENTRIES];
    logic                 pal_vld_reg [PALETTE_ENTRIES];
    logic [AW-1:0]        addr;
    logic                 in_range;

    // stage 1
    logic                 s1_vld_reg;
    logic [23:0]          s1_data_reg;
    logic                 s1_written_reg;
    logic                 s1_in_range_reg;
    logic [7:0]           s1_idx_reg;
    logic [31:0]          s1_prod_reg;
    logic [15:0]          s1_col_reg;
    logic                 s1_we_reg;
    logic                 s1_done_reg;
    logic [33:0]          prod_full;

    // output register
    logic                 out_vld_reg;
    logic                 out_we_reg;
    logic [31:0]          out_addr_reg;
    logic [23:0]          out_rgb_reg;
    logic                 out_done_reg;

    logic                 out_load;
    logic                 s1_free;
    logic                 pal_wr;
    logic                 pix_rd;

    assign out_load = !out_vld_reg || out_ready;
    assign s1_free  = !s1_vld_reg || out_load;
    assign q_pop    = !q_empty && s1_free;
    assign addr     = q_dout.idx[AW-1:0];
    assign in_range = ({1'b0, q_dout.idx} < 9'(PALETTE_ENTRIES));
    assign pal_wr   = q_pop && q_dout.is_pal && in_range;
    assign pix_rd   = q_pop && !q_dout.is_pal;
    assign prod_full = {18'd0, cfg.screen_width} * {16'd0, q_dout.row_sum};

    always_ff @(posedge clk)
    begin
        if (pal_wr)
            mem[addr] <= q_dout.rgb;
        if (pix_rd)
            s1_data_reg <= mem[addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PALETTE_ENTRIES; i++)
                pal_vld_reg[i] <= 1'b0;
        end
        else if (pal_wr)
        begin
            pal_vld_reg[addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_rd)
        begin
            s1_written_reg  <= pal_vld_reg[addr];
            s1_in_range_reg <= in_range;
            s1_idx_reg      <= q_dout.idx;
            s1_prod_reg     <= prod_full[31:0];
            s1_col_reg      <= q_dout.col;
            s1_we_reg       <= q_dout.we;
            s1_done_reg     <= q_dout.done;
        end
        if (out_load && s1_vld_reg)
        begin
            out_we_reg   <= s1_we_reg;
            out_addr_reg <= s1_prod_reg + {16'd0, cfg.frame_left} + {16'd0, s1_col_reg};
            out_done_reg <= s1_done_reg;
            if (!s1_in_range_reg)
                out_rgb_reg <= '0;
            else if (s1_written_reg)
                out_rgb_reg <= s1_data_reg;
            else
                out_rgb_reg <= {s1_idx_reg, s1_idx_reg, s1_idx_reg};  // gray ramp
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
                s1_vld_reg <= pix_rd;
            if (out_load)
                out_vld_reg <= s1_vld_reg;
        end
    end

    assign out_valid     = out_vld_reg;
    assign write_enable  = out_we_reg;
    assign pixel_address = out_addr_reg;
    assign rgb_out       = out_rgb_reg;
    assign frame_done    = out_done_reg;

endmodule
